### sv/khp_pkg.sv
// Shared constants, register indexes and types of the k-mer hash partitioner.
package khp_pkg;

  localparam int KMER_W       = 64;
  localparam int REG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int COLOUR_W_DEF = 16;
  localparam int DIV_STEPS    = KMER_W;

  localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_INDEX      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_COUNT = 2'd2;

  // Running state of a restoring division: dividend bits still to be
  // consumed shift out at the top while quotient bits shift in at the bottom.
  typedef struct packed {
    logic [KMER_W-1:0] word;
    logic [REG_W-1:0]  rem;
  } khp_div_t;

endpackage

### sv/khp_in_if.sv
// Input word channel: one k-mer with its colour tag.
interface khp_in_if #(
  parameter int COLOUR_W = 16
) ();
  logic                valid;
  logic                ready;
  logic [63:0]         kmer_word;
  logic [COLOUR_W-1:0] colour_tag;

  modport source (output valid, output kmer_word, output colour_tag, input ready);
  modport sink (input valid, input kmer_word, input colour_tag, output ready);
endinterface

### sv/khp_out_if.sv
// Result word channel: kept k-mer, its colour and its partition index.
interface khp_out_if #(
  parameter int COLOUR_W = 16
) ();
  logic                valid;
  logic                ready;
  logic [63:0]         kept_kmer;
  logic [COLOUR_W-1:0] kept_colour;
  logic [15:0]         partition_index;

  modport source (output valid, output kept_kmer, output kept_colour,
                  output partition_index, input ready);
  modport sink (input valid, input kept_kmer, input kept_colour,
                input partition_index, output ready);
endinterface

### sv/kmer_hash_partitioner_top.sv
// Top level of the k-mer hash partitioner: hash, two division cell rows, result buffer.
//
// The block takes one word per cycle, a 64-bit k-mer with its colour tag,
// while the result buffer is not full. Each k-mer is scrambled by a
// three-stage integer hash pipeline. A row of 64 division cells then divides
// the hash by the pass count, one quotient bit per cell; the k-mer is kept
// only when the remainder equals the pass index. A second row of 64 identical
// cells divides that quotient by the partition count, and its remainder is the
// partition index. A result word reaches the result channel after its input
// word has passed 3 hash stages, 128 cells and the result buffer, each of
// which adds one register. Dropped k-mers leave no result word. A two-entry
// result buffer sits at the output; the whole pipeline holds while that
// buffer is full, and input ready follows only the buffer fill, never the
// result channel's ready directly. Configuration: register 0 is the pass
// count, register 1 the pass index and register 2 the partition count, each
// 16 bits; a count written as zero behaves as one, writes to other indexes
// are ignored, and registers should be written only while no k-mer is in
// flight.
module kmer_hash_partitioner_top import khp_pkg::*; #(
  parameter int COLOUR_WIDTH = COLOUR_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  khp_in_if.sink               in_ch,
  khp_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  localparam int SIDE_W = KMER_W + COLOUR_WIDTH;
  localparam int BUF_W  = SIDE_W + REG_W;

  // Configuration registers. Counts are stored with zero already mapped to one.
  logic [REG_W-1:0] pass_count_r, pass_index_r, part_count_r;
  logic [REG_W-1:0] cfg_count_nxt;

  assign cfg_count_nxt = (cfg_wdata == '0) ? REG_W'(1) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_count_r <= REG_W'(1);
      pass_index_r <= '0;
      part_count_r <= REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PASS_COUNT:      pass_count_r <= cfg_count_nxt;
        REG_PASS_INDEX:      pass_index_r <= cfg_wdata;
        REG_PARTITION_COUNT: part_count_r <= cfg_count_nxt;
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline advances together unless the result buffer is full.
  logic pipe_en;
  logic buf_full;

  assign pipe_en     = !buf_full;
  assign in_ch.ready = pipe_en;

  logic              in_fire;
  logic [SIDE_W-1:0] in_side;

  assign in_fire = in_ch.valid && pipe_en;
  assign in_side = {in_ch.kmer_word, in_ch.colour_tag};

  // Hash stages.
  logic              hash_vld;
  logic [KMER_W-1:0] hash_val;
  logic [SIDE_W-1:0] hash_side;

  khp_hash #(
    .SIDE_W (SIDE_W)
  ) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (in_fire),
    .in_key   (in_ch.kmer_word),
    .in_side  (in_side),
    .out_vld  (hash_vld),
    .out_hash (hash_val),
    .out_side (hash_side)
  );

  // First cell row: hash divided by the pass count.
  logic              p_vld  [0:DIV_STEPS];
  khp_div_t          p_div  [0:DIV_STEPS];
  logic [SIDE_W-1:0] p_side [0:DIV_STEPS];

  assign p_vld[0]      = hash_vld;
  assign p_div[0].word = hash_val;
  assign p_div[0].rem  = '0;
  assign p_side[0]     = hash_side;

  // Second cell row: pass quotient divided by the partition count.
  logic              q_vld  [0:DIV_STEPS];
  khp_div_t          q_div  [0:DIV_STEPS];
  logic [SIDE_W-1:0] q_side [0:DIV_STEPS];

  // Only k-mers whose pass residue matches enter the second row as valid.
  assign q_vld[0]      = p_vld[DIV_STEPS] && (p_div[DIV_STEPS].rem == pass_index_r);
  assign q_div[0].word = p_div[DIV_STEPS].word;
  assign q_div[0].rem  = '0;
  assign q_side[0]     = p_side[DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cells
    khp_div_cell #(
      .SIDE_W (SIDE_W)
    ) u_pass_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .divisor  (pass_count_r),
      .in_vld   (p_vld[i]),
      .in_div   (p_div[i]),
      .in_side  (p_side[i]),
      .out_vld  (p_vld[i+1]),
      .out_div  (p_div[i+1]),
      .out_side (p_side[i+1])
    );

    khp_div_cell #(
      .SIDE_W (SIDE_W)
    ) u_part_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .divisor  (part_count_r),
      .in_vld   (q_vld[i]),
      .in_div   (q_div[i]),
      .in_side  (q_side[i]),
      .out_vld  (q_vld[i+1]),
      .out_div  (q_div[i+1]),
      .out_side (q_side[i+1])
    );
  end

  // Result buffer holds the k-mer, its colour and the partition index.
  logic              buf_push;
  logic              buf_pop;
  logic              buf_valid;
  logic [BUF_W-1:0]  buf_data;

  assign buf_push = pipe_en && q_vld[DIV_STEPS];
  assign buf_pop  = out_ch.valid && out_ch.ready;

  khp_outbuf #(
    .DATA_W (BUF_W)
  ) u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (buf_push),
    .push_data ({q_side[DIV_STEPS], q_div[DIV_STEPS].rem}),
    .pop       (buf_pop),
    .full      (buf_full),
    .valid     (buf_valid),
    .data      (buf_data)
  );

  assign out_ch.valid           = buf_valid;
  assign out_ch.kept_kmer       = buf_data[BUF_W-1 -: KMER_W];
  assign out_ch.kept_colour     = buf_data[REG_W +: COLOUR_WIDTH];
  assign out_ch.partition_index = buf_data[REG_W-1:0];

  // The stored counts are never zero, so no cell ever divides by zero.
  a_counts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pass_count_r != '0 && part_count_r != '0)
    else $error("zero count stored in configuration");

  // A partition index is always a remainder of the partition count.
  a_partition_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.partition_index < part_count_r)
    else $error("partition index not below partition count");

  // While the buffer is full, the last cell must hold its word.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(q_vld[DIV_STEPS]) && $stable(q_div[DIV_STEPS]))
    else $error("pipeline moved while stalled");

endmodule

### sv/khp_hash.sv
// Three-stage pipeline of the 64-bit shift, xor, multiply and add hash.
module khp_hash import khp_pkg::*; #(
  parameter int SIDE_W = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [KMER_W-1:0] in_key,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [KMER_W-1:0] out_hash,
  output logic [SIDE_W-1:0] out_side
);

  logic [KMER_W-1:0] a_mix, a_sum, a_nxt;
  logic [KMER_W-1:0] b_mul, b_nxt;
  logic [KMER_W-1:0] c_sum, c_nxt;
  logic [KMER_W-1:0] a_r, b_r, c_r;
  logic [SIDE_W-1:0] a_side_r, b_side_r, c_side_r;
  logic [2:0]        vld_r;

  always_comb begin
    a_mix = in_key ^ (in_key >> 14);
    a_sum = (~a_mix) + (a_mix << 18);
    a_nxt = a_sum ^ (a_sum >> 31);
    // Times 21 is 16 + 4 + 1.
    b_mul = a_r + (a_r << 2) + (a_r << 4);
    b_nxt = b_mul ^ (b_mul >> 11);
    c_sum = b_r + (b_r << 6);
    c_nxt = c_sum ^ (c_sum >> 22);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      c_r      <= c_nxt;
      a_side_r <= in_side;
      b_side_r <= a_side_r;
      c_side_r <= b_side_r;
    end
  end

  assign out_vld  = vld_r[2];
  assign out_hash = c_r;
  assign out_side = c_side_r;

endmodule

### sv/khp_div_cell.sv
// One restoring division cell: settles one quotient bit and passes the word on.
module khp_div_cell import khp_pkg::*; #(
  parameter int SIDE_W = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [REG_W-1:0]  divisor,
  input  logic              in_vld,
  input  khp_div_t          in_div,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output khp_div_t          out_div,
  output logic [SIDE_W-1:0] out_side
);

  logic [REG_W:0]    trial;
  logic [REG_W:0]    diff;
  logic              fits;
  khp_div_t          div_nxt;
  logic              vld_r;
  khp_div_t          div_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    trial = {in_div.rem, in_div.word[KMER_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
    // The remainder stays below the divisor, so it always fits REG_W bits.
    div_nxt.rem  = fits ? diff[REG_W-1:0] : trial[REG_W-1:0];
    div_nxt.word = {in_div.word[KMER_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= div_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_div  = div_r;
  assign out_side = side_r;

endmodule

### sv/khp_outbuf.sv
// Two-entry result buffer that decouples the pipeline from the result channel.
module khp_outbuf #(
  parameter int DATA_W = 96
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              full,
  output logic              valid,
  output logic [DATA_W-1:0] data
);

  logic [DATA_W-1:0] mem_r [0:1];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign data  = mem_r[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("result buffer written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("result buffer read while empty");

endmodule
